// ----- hw/rtl/mrbrb_pkg.sv -----
package mrbrb_pkg;

	localparam int RING_DEPTH = 1024;
	localparam int MAX_BURST  = 64;
	localparam int AW         = $clog2(RING_DEPTH);
	localparam int SIZE_W     = AW + 1;
	localparam int LEN_W      = $clog2(MAX_BURST + 1);
	localparam int QDEPTH     = 4;
	localparam int QAW        = $clog2(QDEPTH);

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;
	localparam logic [1:0] CMD_SPARE = 2'd3;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_BAD_PTR = 1'b1;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
		logic [9:0] read_ptr;
		logic [6:0] read_len;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic [9:0] new_read_ptr;
		logic [9:0] count;
		logic       last;
		logic       status;
	} rsp_t;

	typedef enum logic [1:0] {
		K_WRITE,
		K_READ,
		K_QUERY,
		K_ERROR
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       data_byte;
		logic [AW-1:0]    read_ptr;
		logic [LEN_W-1:0] read_len;
	} entry_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC,
		ST_BURST
	} back_state_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
		logic [SIZE_W-1:0] r;
		if (v < SIZE_W'(2))
			r = SIZE_W'(2);
		else if (v > SIZE_W'(RING_DEPTH))
			r = SIZE_W'(RING_DEPTH);
		else
			r = v;
		return r;
	endfunction

endpackage

// ----- hw/rtl/mrbrb_front.sv -----
module mrbrb_front (
	input  mrbrb_pkg::req_t                    req,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [mrbrb_pkg::SIZE_W-1:0]       size,
	input  logic                               full,
	input  logic                               clearing,
	output logic                               push,
	output mrbrb_pkg::entry_t                  entry
);
	import mrbrb_pkg::*;

	assign req_stall = full | clearing;
	assign push      = req_valid & ~req_stall & (req.cmd != CMD_SPARE);

	always_comb begin
		entry.data_byte = req.data_byte;
		entry.read_ptr  = req.read_ptr;
		entry.read_len  = (req.read_len > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST) : req.read_len;
		if (req.cmd == CMD_WRITE)
			entry.kind = K_WRITE;
		else if ({1'b0, req.read_ptr} >= size)
			entry.kind = K_ERROR;
		else if (req.cmd == CMD_READ)
			entry.kind = K_READ;
		else
			entry.kind = K_QUERY;
	end

endmodule

// ----- hw/rtl/mrbrb_queue.sv -----
module mrbrb_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mrbrb_pkg::entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output mrbrb_pkg::entry_t head
);
	import mrbrb_pkg::*;

	entry_t         slot_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;

	assign full       = (cnt_q == (QAW+1)'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_entry;
	end

endmodule

// ----- hw/rtl/mrbrb_back.sv -----
module mrbrb_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [mrbrb_pkg::SIZE_W-1:0] size,
	input  logic                         cfg_we,
	input  logic                         head_valid,
	input  mrbrb_pkg::entry_t            head,
	output logic                         pop,
	output logic                         clearing,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output mrbrb_pkg::rsp_t              rsp
);
	import mrbrb_pkg::*;

	logic [7:0] mem_q [RING_DEPTH];

	back_state_t      state_q, state_d;
	logic [AW-1:0]    clr_q;
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [LEN_W-1:0] len_q;
	logic [AW-1:0]    lev_q;
	logic             is_query_q;
	logic [AW-1:0]    pos_q;
	logic [AW-1:0]    nptr_q;
	logic [LEN_W-1:0] n_q;
	logic [LEN_W-1:0] rem_q;
	logic [7:0]       rd_q;
	logic             out_valid_q;
	logic             o_byte_valid_q;
	logic [AW-1:0]    o_nptr_q;
	logic [9:0]       o_count_q;
	logic             o_last_q;
	logic             o_status_q;

	logic              adv;
	logic [SIZE_W-1:0] lev_w;
	logic [LEN_W-1:0]  n_c;
	logic [SIZE_W-1:0] nsum;
	logic [AW-1:0]     nptr_c;
	logic [SIZE_W-1:0] pos_inc;
	logic [AW-1:0]     pos_next;
	logic [SIZE_W-1:0] wp_inc;
	logic [AW-1:0]     wp_next;

	logic              mem_we;
	logic [AW-1:0]     waddr;
	logic [7:0]        wdata;
	logic              mem_re;
	logic              take;
	logic              wp_step;
	logic              start_burst;
	logic              step;
	logic              ld;
	logic              ld_byte_valid;
	logic [AW-1:0]     ld_nptr;
	logic [9:0]        ld_count;
	logic              ld_last;
	logic              ld_status;

	assign adv      = ~out_valid_q | ~rsp_stall;
	assign clearing = (state_q == ST_CLEAR);

	always_comb begin
		if (wp_q >= head.read_ptr)
			lev_w = {1'b0, wp_q} - {1'b0, head.read_ptr};
		else
			lev_w = {1'b0, wp_q} + size - {1'b0, head.read_ptr};
	end

	assign n_c      = (lev_q < AW'(len_q)) ? lev_q[LEN_W-1:0] : len_q;
	assign nsum     = {1'b0, rp_q} + SIZE_W'(n_c);
	assign nptr_c   = (nsum >= size) ? AW'(nsum - size) : nsum[AW-1:0];
	assign pos_inc  = {1'b0, pos_q} + 1'b1;
	assign pos_next = (pos_inc >= size) ? '0 : pos_inc[AW-1:0];
	assign wp_inc   = {1'b0, wp_q} + 1'b1;
	assign wp_next  = (wp_inc >= size) ? '0 : wp_inc[AW-1:0];

	always_comb begin
		state_d       = state_q;
		pop           = 1'b0;
		mem_we        = 1'b0;
		waddr         = wp_q;
		wdata         = head.data_byte;
		mem_re        = 1'b0;
		take          = 1'b0;
		wp_step       = 1'b0;
		start_burst   = 1'b0;
		step          = 1'b0;
		ld            = 1'b0;
		ld_byte_valid = 1'b0;
		ld_nptr       = rp_q;
		ld_count      = '0;
		ld_last       = 1'b1;
		ld_status     = STATUS_OK;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				waddr  = clr_q;
				wdata  = '0;
				if (clr_q == AW'(RING_DEPTH - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (head_valid) begin
					unique case (head.kind)
						K_WRITE: begin
							pop     = 1'b1;
							mem_we  = 1'b1;
							wp_step = 1'b1;
						end
						K_ERROR: begin
							if (adv) begin
								pop       = 1'b1;
								ld        = 1'b1;
								ld_nptr   = head.read_ptr;
								ld_status = STATUS_BAD_PTR;
							end
						end
						K_READ, K_QUERY: begin
							pop     = 1'b1;
							take    = 1'b1;
							state_d = ST_CALC;
						end
					endcase
				end
			end
			ST_CALC: begin
				if (is_query_q || n_c == '0) begin
					if (adv) begin
						ld       = 1'b1;
						ld_count = is_query_q ? 10'(lev_q) : '0;
						state_d  = ST_IDLE;
					end
				end else begin
					start_burst = 1'b1;
					state_d     = ST_BURST;
				end
			end
			ST_BURST: begin
				if (adv) begin
					mem_re        = 1'b1;
					step          = 1'b1;
					ld            = 1'b1;
					ld_byte_valid = 1'b1;
					ld_nptr       = nptr_q;
					ld_count      = 10'(n_q);
					ld_last       = (rem_q == LEN_W'(1));
					if (rem_q == LEN_W'(1))
						state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			wp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (cfg_we)
				wp_q <= '0;
			else if (wp_step)
				wp_q <= wp_next;
			if (adv)
				out_valid_q <= ld;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rp_q       <= head.read_ptr;
			len_q      <= head.read_len;
			lev_q      <= lev_w[AW-1:0];
			is_query_q <= (head.kind == K_QUERY);
		end
		if (start_burst) begin
			pos_q  <= rp_q;
			nptr_q <= nptr_c;
			n_q    <= n_c;
			rem_q  <= n_c;
		end else if (step) begin
			pos_q <= pos_next;
			rem_q <= rem_q - 1'b1;
		end
		if (adv && ld) begin
			o_byte_valid_q <= ld_byte_valid;
			o_nptr_q       <= ld_nptr;
			o_count_q      <= ld_count;
			o_last_q       <= ld_last;
			o_status_q     <= ld_status;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[waddr] <= wdata;
		if (mem_re)
			rd_q <= mem_q[pos_q];
	end

	assign rsp_valid = out_valid_q;

	always_comb begin
		rsp.out_byte     = o_byte_valid_q ? rd_q : '0;
		rsp.byte_valid   = o_byte_valid_q;
		rsp.new_read_ptr = o_nptr_q;
		rsp.count        = o_count_q;
		rsp.last         = o_last_q;
		rsp.status       = o_status_q;
	end

endmodule

// ----- hw/rtl/multi_reader_byte_ring_buffer.sv -----
// Byte ring with one writer and any number of readers that each keep their own read
// pointer outside the block. A write is done by the back end in its idle state and overwrites
// the oldest data; it waits only behind earlier items in the queue. A level query is
// answered from the calculation state once the output register is free; a read burst
// works out level, length and new pointer, then delivers one byte a cycle from the ring
// memory as long as the output register is free, that is while results are not stalled.
// A four-entry queue between the decoder and the back end absorbs input while results
// are stalled; req_stall rises when it is full. After reset the ring is cleared one byte
// a cycle, all 1024 bytes, during which req_stall stays high; cfg_we is taken at any time
// and also resets the write pointer to zero.
module multi_reader_byte_ring_buffer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [mrbrb_pkg::SIZE_W-1:0] cfg_wdata,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  mrbrb_pkg::req_t              req,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output mrbrb_pkg::rsp_t              rsp
);
	import mrbrb_pkg::*;

	logic [SIZE_W-1:0] size_q;
	logic              full;
	logic              clearing;
	logic              push;
	entry_t            push_entry;
	logic              pop;
	logic              head_valid;
	entry_t            head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			size_q <= SIZE_W'(RING_DEPTH);
		else if (cfg_we)
			size_q <= clamp_size(cfg_wdata);
	end

	mrbrb_front u_front (
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.size      (size_q),
		.full      (full),
		.clearing  (clearing),
		.push      (push),
		.entry     (push_entry)
	);

	mrbrb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	mrbrb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.size       (size_q),
		.cfg_we     (cfg_we),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.clearing   (clearing),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule

// ----- bench/tb_multi_reader_byte_ring_buffer.sv -----
`timescale 1ns / 1ps

module tb_multi_reader_byte_ring_buffer;
	import mrbrb_pkg::*;

	localparam int         READERS        = 4;
	localparam int         RANDOM_ITEMS   = 160;
	localparam int         SETTLE_CYCLES  = 16;
	localparam int unsigned SIZE_PICKS [8] = '{1024, 17, 2, 1023, 65, 513, 3, 64};

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [SIZE_W-1:0] cfg_wdata;
	logic              req_valid;
	logic              req_stall;
	req_t              req;
	logic              rsp_valid;
	logic              rsp_stall;
	rsp_t              rsp;

	logic [7:0]   ring_copy [0:RING_DEPTH-1];
	int unsigned  wr_pos;
	int unsigned  ring_size;
	int unsigned  last_new_ptr;
	int unsigned  reader_ptr [READERS];
	rsp_t         answers_due [$];
	int           mismatches;
	bit           calm;

	multi_reader_byte_ring_buffer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk) begin
		rsp_stall <= !calm && ($urandom_range(99) < 8);
	end

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("%0t ns: rsp %s got %0d, want %0d", $time, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_rsp
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (answers_due.size() == 0) begin
				report_mismatch("transaction with none due, count", int'(rsp.count), 0);
			end else begin
				want = answers_due.pop_front();
				if (rsp.out_byte !== want.out_byte)
					report_mismatch("out_byte", int'(rsp.out_byte), int'(want.out_byte));
				if (rsp.byte_valid !== want.byte_valid)
					report_mismatch("byte_valid", int'(rsp.byte_valid),
						int'(want.byte_valid));
				if (rsp.new_read_ptr !== want.new_read_ptr)
					report_mismatch("new_read_ptr", int'(rsp.new_read_ptr),
						int'(want.new_read_ptr));
				if (rsp.count !== want.count)
					report_mismatch("count", int'(rsp.count), int'(want.count));
				if (rsp.last !== want.last)
					report_mismatch("last", int'(rsp.last), int'(want.last));
				if (rsp.status !== want.status)
					report_mismatch("status", int'(rsp.status), int'(want.status));
			end
		end
	end

	task automatic predict_ring_answer(input req_t r);
		int unsigned rp;
		int unsigned lvl;
		int unsigned lim;
		int unsigned n;
		int unsigned pos;
		rsp_t a;
		rp = 32'(r.read_ptr);
		a = '0;
		a.last = 1'b1;
		a.status = STATUS_OK;
		a.new_read_ptr = r.read_ptr;
		case (r.cmd)
			CMD_WRITE: begin
				if (wr_pos >= ring_size)
					wr_pos = 0;
				ring_copy[wr_pos[AW-1:0]] = r.data_byte;
				wr_pos = (wr_pos + 1) % ring_size;
			end
			CMD_READ, CMD_QUERY: begin
				last_new_ptr = rp;
				if (rp >= ring_size) begin
					a.status = STATUS_BAD_PTR;
					answers_due.push_back(a);
				end else begin
					lvl = (ring_size + wr_pos - rp) % ring_size;
					if (r.cmd == CMD_QUERY) begin
						a.count = 10'(lvl);
						answers_due.push_back(a);
					end else begin
						lim = (32'(r.read_len) > MAX_BURST) ? MAX_BURST : 32'(r.read_len);
						n = (lvl < lim) ? lvl : lim;
						if (n == 0) begin
							answers_due.push_back(a);
						end else begin
							last_new_ptr = (rp + n) % ring_size;
							pos = rp;
							for (int i = 0; i < n; i++) begin
								a.out_byte = ring_copy[pos[AW-1:0]];
								a.byte_valid = 1'b1;
								a.new_read_ptr = 10'(last_new_ptr);
								a.count = 10'(n);
								a.last = (i == n - 1);
								answers_due.push_back(a);
								pos = (pos + 1 >= ring_size) ? 0 : pos + 1;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	function automatic req_t make_req(input logic [1:0] cmd, input int unsigned data,
			input int unsigned ptr, input int unsigned len);
		req_t r;
		r.cmd = cmd;
		r.data_byte = 8'(data);
		r.read_ptr = 10'(ptr);
		r.read_len = 7'(len);
		return r;
	endfunction

	// Call at a falling edge; returns at the falling edge after the transaction.
	task automatic send_request(input req_t item);
		while (!calm && $urandom_range(99) < 8) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req = item;
		do @(posedge clk); while (req_stall);
		predict_ring_answer(item);
		@(negedge clk);
	endtask

	task automatic drain_answers();
		req_valid = 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_size(input int unsigned v);
		cfg_we = 1'b1;
		cfg_wdata = SIZE_W'(v);
		@(negedge clk);
		cfg_we = 1'b0;
		if (v < 2)
			ring_size = 2;
		else if (v > RING_DEPTH)
			ring_size = RING_DEPTH;
		else
			ring_size = v;
		wr_pos = 0;
	endtask

	task automatic test_after_reset();
		send_request(make_req(CMD_QUERY, 0, 0, 0));
		send_request(make_req(CMD_READ, 0, 0, 5));
		send_request(make_req(CMD_READ, 0, 1023, 127));
		send_request(make_req(CMD_WRITE, 8'h00, 0, 0));
		send_request(make_req(CMD_WRITE, 8'hFF, 1023, 127));
		send_request(make_req(CMD_WRITE, 8'hA5, 0, 0));
		send_request(make_req(CMD_WRITE, 8'h5A, 0, 0));
		send_request(make_req(CMD_READ, 0, 0, 127));
		send_request(make_req(CMD_SPARE, 8'hFF, 1023, 127));
		send_request(make_req(CMD_QUERY, 0, 1023, 0));
		send_request(make_req(CMD_READ, 0, 2, 1));
	endtask

	task automatic test_size_extremes();
		drain_answers();
		write_size(0);
		send_request(make_req(CMD_WRITE, 8'h11, 0, 0));
		send_request(make_req(CMD_WRITE, 8'h22, 0, 0));
		send_request(make_req(CMD_WRITE, 8'h33, 0, 0));
		send_request(make_req(CMD_READ, 0, 0, 64));
		send_request(make_req(CMD_READ, 0, 2, 3));
		send_request(make_req(CMD_QUERY, 0, 1023, 0));
		drain_answers();
		write_size(1);
		send_request(make_req(CMD_QUERY, 0, 1, 0));
		drain_answers();
		write_size(2047);
		send_request(make_req(CMD_QUERY, 0, 1000, 0));
		send_request(make_req(CMD_READ, 0, 1020, 4));
		send_request(make_req(CMD_READ, 0, 900, 127));
	endtask

	task automatic test_random_streams();
		int unsigned sent;
		int unsigned phase;
		int unsigned pick;
		int unsigned k;
		int unsigned burst;
		int unsigned len;
		logic [1:0]  cmd;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			drain_answers();
			write_size((phase < 8) ? SIZE_PICKS[phase[2:0]] : $urandom_range(2047));
			for (int i = 0; i < READERS; i++)
				reader_ptr[i] = (i < 2) ? 0 : $urandom_range(ring_size - 1);
			calm = (phase == 1);
			repeat (6) begin
				pick = $urandom_range(99);
				k = $urandom_range(READERS - 1);
				if (pick < 50) begin
					burst = $urandom_range(1, 24);
					repeat (burst)
						send_request(make_req(CMD_WRITE, $urandom_range(255),
							$urandom_range(1023), $urandom_range(127)));
					sent += burst;
				end else if (pick < 82) begin
					len = ($urandom_range(9) == 0) ? $urandom_range(65, 127) :
						$urandom_range(64);
					send_request(make_req(CMD_READ, $urandom_range(255), reader_ptr[k], len));
					reader_ptr[k] = last_new_ptr;
					sent++;
				end else if (pick < 92) begin
					send_request(make_req(CMD_QUERY, $urandom_range(255), reader_ptr[k],
						$urandom_range(127)));
					sent++;
				end else begin
					cmd = 2'($urandom_range(1, 3));
					send_request(make_req(cmd, $urandom_range(255), $urandom_range(1023),
						$urandom_range(127)));
					if (cmd != CMD_SPARE)
						sent++;
				end
			end
			phase++;
		end
		calm = 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_valid = 1'b0;
		req = '0;
		calm = 1'b0;
		mismatches = 0;
		wr_pos = 0;
		ring_size = RING_DEPTH;
		last_new_ptr = 0;
		for (int i = 0; i < RING_DEPTH; i++)
			ring_copy[i] = 8'h00;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_after_reset();
		test_size_extremes();
		test_random_streams();
		drain_answers();

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
